>>> rtl/core/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes for the circular deque block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    localparam logic [2:0] MODE_INS_FRONT = 3'd0;
    localparam logic [2:0] MODE_INS_REAR  = 3'd1;
    localparam logic [2:0] MODE_REM_FRONT = 3'd2;
    localparam logic [2:0] MODE_REM_REAR  = 3'd3;
    localparam logic [2:0] MODE_LOOK      = 3'd4;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [7:0] CAPACITY_RESET = 8'd128;

    typedef struct packed {
        logic op_en;
        logic rd_en;
        logic out_load;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/cdq_if.sv
// ----------------------------------------------------------------------------
// cdq_if
// Valid/ready channel interfaces for requests, responses and configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cdq_req_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  mode;
    logic signed [31:0] key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

interface cdq_rsp_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic               now_empty;
    logic               now_full;

    modport source (output valid, output status, output front_value,
                    output rear_value, output now_empty, output now_full,
                    input ready);
    modport sink   (input valid, input status, input front_value,
                    input rear_value, input now_empty, input now_full,
                    output ready);
endinterface

interface cdq_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer for one transaction: operate, read the store, load the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdq_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    output cdq_pkg::cmd_t     cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.op_en    = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.out_load = 1'b0;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op_en  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> rtl/core/cdq_datapath.sv
// ----------------------------------------------------------------------------
// cdq_datapath
// Entry store, front and rear indices, capacity register and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdq_datapath #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cdq_pkg::cmd_t      cmd,
    input  wire logic               cfg_we,
    input  wire logic        [7:0]  cfg_data,
    input  wire logic        [2:0]  mode,
    input  wire logic signed [31:0] key,
    output logic             [1:0]  status,
    output logic signed      [31:0] front_value,
    output logic signed      [31:0] rear_value,
    output logic                    now_empty,
    output logic                    now_full
);

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CAPW = (CW > 8) ? CW : 8;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_f_reg;
    logic [DATA_WIDTH-1:0] rd_r_reg;

    logic [7:0]    capacity_reg;
    logic [IW-1:0] front_reg;
    logic [IW-1:0] rear_reg;
    logic          empty_reg;
    logic [1:0]    status_reg;

    logic [IW-1:0] front_next;
    logic [IW-1:0] rear_next;
    logic          empty_next;
    logic [1:0]    status_next;

    logic [CAPW-1:0] cap_ext;
    logic [CAPW-1:0] cap_use;
    logic [CAPW-1:0] f_ext;
    logic [CAPW-1:0] r_ext;
    logic [IW-1:0]   last_idx;
    logic [IW-1:0]   f_inc;
    logic [IW-1:0]   f_dec;
    logic [IW-1:0]   r_inc;
    logic [IW-1:0]   r_dec;
    logic            full;
    logic            wr_en;
    logic [IW-1:0]   wr_pos;
    logic [DATA_WIDTH-1:0] wr_data;

    always_comb
    begin
        cap_ext = CAPW'(capacity_reg);
        if (cap_ext == '0)
        begin
            cap_use = CAPW'(1);
        end
        else if (cap_ext > CAPW'(DEPTH))
        begin
            cap_use = CAPW'(DEPTH);
        end
        else
        begin
            cap_use = cap_ext;
        end
    end

    assign f_ext    = CAPW'(front_reg);
    assign r_ext    = CAPW'(rear_reg);
    assign last_idx = IW'(cap_use - CAPW'(1));

    assign f_inc = (f_ext + CAPW'(1) >= cap_use) ? '0 : IW'(f_ext + CAPW'(1));
    assign r_inc = (r_ext + CAPW'(1) >= cap_use) ? '0 : IW'(r_ext + CAPW'(1));
    assign f_dec = (f_ext == '0 || f_ext >= cap_use) ? last_idx : IW'(f_ext - CAPW'(1));
    assign r_dec = (r_ext == '0 || r_ext >= cap_use) ? last_idx : IW'(r_ext - CAPW'(1));

    assign full = !empty_reg &&
                  ((f_ext == '0 && r_ext == cap_use - CAPW'(1)) ||
                   (f_ext == r_ext + CAPW'(1)));

    assign wr_data = DATA_WIDTH'($unsigned(key));

    always_comb
    begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        empty_next  = empty_reg;
        status_next = cdq_pkg::ST_DONE;
        wr_en       = 1'b0;
        wr_pos      = '0;
        case (mode) inside
            cdq_pkg::MODE_INS_FRONT, cdq_pkg::MODE_INS_REAR:
            begin
                if (full)
                begin
                    status_next = cdq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (empty_reg)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                        empty_next = 1'b0;
                    end
                    else if (mode == cdq_pkg::MODE_INS_FRONT)
                    begin
                        front_next = f_dec;
                        wr_pos     = f_dec;
                    end
                    else
                    begin
                        rear_next = r_inc;
                        wr_pos    = r_inc;
                    end
                end
            end
            cdq_pkg::MODE_REM_FRONT, cdq_pkg::MODE_REM_REAR:
            begin
                if (empty_reg)
                begin
                    status_next = cdq_pkg::ST_UNDERFLOW;
                end
                else if (front_reg == rear_reg)
                begin
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b1;
                end
                else if (mode == cdq_pkg::MODE_REM_FRONT)
                begin
                    front_next = f_inc;
                end
                else
                begin
                    rear_next = r_dec;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= cdq_pkg::CAPACITY_RESET;
            front_reg    <= '0;
            rear_reg     <= '0;
            empty_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_data;
            front_reg    <= '0;
            rear_reg     <= '0;
            empty_reg    <= 1'b1;
        end
        else if (cmd.op_en)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op_en && wr_en)
        begin
            mem[wr_pos] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_f_reg <= mem[front_reg];
            rd_r_reg <= mem[rear_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op_en)
        begin
            status_reg <= status_next;
        end
        if (cmd.out_load)
        begin
            status    <= status_reg;
            now_empty <= empty_reg;
            now_full  <= full;
            if (empty_reg)
            begin
                front_value <= '1;
                rear_value  <= '1;
            end
            else
            begin
                front_value <= 32'($signed(rd_f_reg));
                rear_value  <= 32'($signed(rd_r_reg));
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue in a circular store with a programmable capacity.
// ----------------------------------------------------------------------------
// The req channel carries one operation per transaction: insert at the front
// or rear, remove from the front or rear, or look only. The rsp channel
// returns one transaction per request with the status, the front and rear
// values after the operation (all ones when empty) and the empty and full
// flags. The cfg channel writes the capacity and empties the deque; it is
// always ready. It is to be written only while no request is in progress;
// the block itself does not enforce this. A request passes in order through
// the operation and store write, the registered read of the store at both
// indices, and the load of the response register. A new request is taken
// only once the previous one has loaded the response register.
// The response register holds a finished result while the next request is
// already accepted; if the receiver stalls, the following result waits
// inside the block and req stays not ready until the register frees up.
// Reset empties the deque and sets the capacity to 128; the store contents
// are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module circular_deque #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cdq_req_if.sink    req,
    cdq_rsp_if.source  rsp,
    cdq_cfg_if.sink    cfg
);

    cdq_pkg::cmd_t cmd;

    assign cfg.ready = 1'b1;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg.valid && cfg.ready),
        .cfg_data    (cfg.data),
        .mode        (req.mode),
        .key         (req.key),
        .status      (rsp.status),
        .front_value (rsp.front_value),
        .rear_value  (rsp.rear_value),
        .now_empty   (rsp.now_empty),
        .now_full    (rsp.now_full)
    );

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("Request accepted while another was in progress.");

    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.now_empty |->
            (rsp.front_value == 32'hFFFF_FFFF && rsp.rear_value == 32'hFFFF_FFFF))
        else $error("Empty deque reported values other than all ones.");

    a_empty_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.now_empty && rsp.now_full))
        else $error("Deque reported empty and full at once.");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == cdq_pkg::ST_UNDERFLOW |-> rsp.now_empty)
        else $error("Underflow reported on a deque that is not empty.");
`endif

endmodule

`default_nettype wire

>>> tb/circular_deque_tb.sv
// ----------------------------------------------------------------------------
// circular_deque_tb
// Self-checking testbench for the circular deque block.
// ----------------------------------------------------------------------------
// A behavioral deque model inside the testbench predicts the response to
// every request transaction that the block accepts. A separate process
// compares each response transaction with the oldest prediction. Directed
// tests cover the empty deque after reset, extreme keys, a zero capacity
// and a wrap around a capacity of two. Random phases follow at several
// capacities, where fill and drain runs push the deque into full and empty.
// The sender works in bursts, and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circular_deque_tb;

    localparam int DEPTH        = 128;
    localparam int SETTLE_TICKS = 6;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [2:0] MODE_UNUSED_5 = 3'd5;
    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

    localparam logic [31:0] KEY_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] KEY_MIN   = 32'h8000_0000;
    localparam logic [31:0] KEY_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] KEY_ZERO  = 32'h0000_0000;
    localparam logic [31:0] NO_ENTRY  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] front_value;
        logic [31:0] rear_value;
        logic        now_empty;
        logic        now_full;
    } deque_result_t;

    typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_BEAT} rx_style_t;

    logic clk = 1'b0;
    logic rst_n;

    cdq_req_if req_if ();
    cdq_rsp_if rsp_if ();
    cdq_cfg_if cfg_if ();

    circular_deque dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // Deque model state.
    logic [31:0] slot_mem [DEPTH];
    int unsigned head_idx;
    int unsigned tail_idx;
    bit          deque_empty;
    logic [7:0]  capacity_reg;

    deque_result_t expected_results [$];
    int unsigned   mismatch_count;
    int unsigned   cycle_count;
    int unsigned   burst_left;
    bit            req_driving;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int unsigned cap_used();
        if (capacity_reg == 8'd0)
            return 1;
        if (capacity_reg > DEPTH)
            return DEPTH;
        return 32'(capacity_reg);
    endfunction

    function automatic int unsigned wrap_next(int unsigned i, int unsigned cap);
        return (i + 1 >= cap) ? 0 : i + 1;
    endfunction

    function automatic int unsigned wrap_prev(int unsigned i, int unsigned cap);
        return (i == 0 || i >= cap) ? cap - 1 : i - 1;
    endfunction

    function automatic bit deque_full(int unsigned cap);
        if (deque_empty)
            return 1'b0;
        return (head_idx == 0 && tail_idx == cap - 1) || (head_idx == tail_idx + 1);
    endfunction

    function automatic void clear_deque();
        head_idx    = 0;
        tail_idx    = 0;
        deque_empty = 1'b1;
    endfunction

    function automatic deque_result_t deque_apply(logic [2:0] mode, logic [31:0] key);
        int unsigned   cap;
        int unsigned   pos;
        deque_result_t res;
        cap = cap_used();
        res.status = cdq_pkg::ST_DONE;
        if (mode == cdq_pkg::MODE_INS_FRONT || mode == cdq_pkg::MODE_INS_REAR)
        begin
            if (deque_full(cap))
                res.status = cdq_pkg::ST_OVERFLOW;
            else
            begin
                if (deque_empty)
                begin
                    head_idx    = 0;
                    tail_idx    = 0;
                    deque_empty = 1'b0;
                    pos         = 0;
                end
                else if (mode == cdq_pkg::MODE_INS_FRONT)
                begin
                    head_idx = wrap_prev(head_idx, cap);
                    pos      = head_idx;
                end
                else
                begin
                    tail_idx = wrap_next(tail_idx, cap);
                    pos      = tail_idx;
                end
                slot_mem[pos] = key;
            end
        end
        else if (mode == cdq_pkg::MODE_REM_FRONT || mode == cdq_pkg::MODE_REM_REAR)
        begin
            if (deque_empty)
                res.status = cdq_pkg::ST_UNDERFLOW;
            else if (head_idx == tail_idx)
                clear_deque();
            else if (mode == cdq_pkg::MODE_REM_FRONT)
                head_idx = wrap_next(head_idx, cap);
            else
                tail_idx = wrap_prev(tail_idx, cap);
        end
        res.front_value = deque_empty ? NO_ENTRY : slot_mem[head_idx];
        res.rear_value  = deque_empty ? NO_ENTRY : slot_mem[tail_idx];
        res.now_empty   = deque_empty;
        res.now_full    = deque_full(cap);
        return res;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s", $realtime, what);
    endtask

    // Response checker.
    always @(posedge clk)
    begin
        deque_result_t got;
        deque_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = '{rsp_if.status, rsp_if.front_value, rsp_if.rear_value,
                    rsp_if.now_empty, rsp_if.now_full};
            if (expected_results.size() == 0)
                report_mismatch($sformatf({"unexpected response: status %0d front %h ",
                    "rear %h empty %0b full %0b"},
                    got.status, got.front_value, got.rear_value, got.now_empty, got.now_full));
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                    report_mismatch($sformatf({"expected status %0d front %h rear %h ",
                        "empty %0b full %0b, ",
                        "got status %0d front %h rear %h empty %0b full %0b"},
                        want.status, want.front_value, want.rear_value,
                        want.now_empty, want.now_full,
                        got.status, got.front_value, got.rear_value,
                        got.now_empty, got.now_full));
            end
        end
    end

    // Receiver with a stall pattern that is chosen anew whenever its timer runs out.
    initial
    begin
        rx_style_t   rx_style;
        int unsigned rx_timer;
        rx_style = RX_OPEN;
        rx_timer = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_timer == 0)
            begin
                rx_style = rx_style_t'($urandom_range(0, 3));
                rx_timer = $urandom_range(20, 80);
            end
            rx_timer--;
            case (rx_style)
                RX_OPEN:   rsp_if.ready <= 1'b1;
                RX_HALF:   rsp_if.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                default:   rsp_if.ready <= ((rx_timer % 5) < 2);
            endcase
        end
    end

    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            req_if.valid <= 1'b0;
            req_driving = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                      : $urandom_range(1, 24);
        end
    endtask

    task automatic send_op(logic [2:0] mode, logic [31:0] key);
        req_if.valid <= 1'b1;
        req_if.mode  <= mode;
        req_if.key   <= key;
        req_driving = 1'b1;
        do
            @(posedge clk);
        while (!req_if.ready);
        expected_results.push_back(deque_apply(mode, key));
        pace_sender();
    endtask

    task automatic wait_idle();
        if (req_driving)
        begin
            req_if.valid <= 1'b0;
            req_driving = 1'b0;
        end
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_capacity(logic [7:0] value);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        capacity_reg = value;
        clear_deque();
        @(posedge clk);
    endtask

    function automatic logic [31:0] random_key();
        case ($urandom_range(0, 11))
            0:       return KEY_MAX;
            1:       return KEY_MIN;
            2:       return KEY_ZERO;
            3:       return KEY_ONES;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_after_reset();
        send_op(cdq_pkg::MODE_LOOK, random_key());
        send_op(cdq_pkg::MODE_REM_FRONT, random_key());
        send_op(cdq_pkg::MODE_REM_REAR, random_key());
        send_op(MODE_UNUSED_5, random_key());
        send_op(MODE_UNUSED_6, random_key());
        send_op(MODE_UNUSED_7, random_key());
    endtask

    task automatic test_extreme_keys();
        send_op(cdq_pkg::MODE_INS_REAR, KEY_MAX);
        send_op(cdq_pkg::MODE_INS_FRONT, KEY_MIN);
        send_op(cdq_pkg::MODE_INS_REAR, KEY_ZERO);
        send_op(cdq_pkg::MODE_INS_FRONT, KEY_ONES);
        send_op(cdq_pkg::MODE_REM_FRONT, random_key());
        send_op(cdq_pkg::MODE_REM_REAR, random_key());
        send_op(cdq_pkg::MODE_REM_FRONT, random_key());
        send_op(cdq_pkg::MODE_REM_REAR, random_key());
    endtask

    task automatic test_zero_capacity();
        write_capacity(8'd0);
        send_op(cdq_pkg::MODE_INS_REAR, random_key());
        send_op(cdq_pkg::MODE_INS_FRONT, random_key());
        send_op(cdq_pkg::MODE_REM_FRONT, random_key());
    endtask

    task automatic test_wraparound();
        write_capacity(8'd2);
        send_op(cdq_pkg::MODE_INS_FRONT, random_key());
        send_op(cdq_pkg::MODE_INS_FRONT, random_key());
        send_op(cdq_pkg::MODE_INS_REAR, random_key());
        send_op(cdq_pkg::MODE_REM_REAR, random_key());
        send_op(cdq_pkg::MODE_INS_REAR, random_key());
        send_op(cdq_pkg::MODE_REM_FRONT, random_key());
    endtask

    // Fill and drain runs with random ends and keys, plus some noise.
    task automatic run_random_mix(logic [7:0] capacity, int unsigned count);
        bit          filling;
        int unsigned sel;
        logic [2:0]  mode;
        write_capacity(capacity);
        filling = 1'b1;
        repeat (count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
                mode = 3'($urandom_range(cdq_pkg::MODE_LOOK, MODE_UNUSED_7));
            else if (sel < (filling ? 82 : 26))
                mode = $urandom_range(0, 1) ? cdq_pkg::MODE_INS_FRONT
                                            : cdq_pkg::MODE_INS_REAR;
            else
                mode = $urandom_range(0, 1) ? cdq_pkg::MODE_REM_FRONT
                                            : cdq_pkg::MODE_REM_REAR;
            send_op(mode, random_key());
            if (deque_full(cap_used()))
                filling = 1'b0;
            else if (deque_empty)
                filling = 1'b1;
            else if ($urandom_range(0, 19) == 0)
                filling = !filling;
        end
    endtask

    task automatic test_random_phases();
        run_random_mix(8'd255, 290);
        run_random_mix(8'd1, 20);
        run_random_mix(8'd2, 25);
        run_random_mix(8'd3, 25);
        run_random_mix(8'd6, 30);
        run_random_mix(8'($urandom_range(8, 40)), 40);
        run_random_mix(cdq_pkg::CAPACITY_RESET, 60);
    endtask

    initial
    begin
        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 1;
        req_driving    = 1'b0;
        capacity_reg   = cdq_pkg::CAPACITY_RESET;
        clear_deque();
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.mode    <= cdq_pkg::MODE_LOOK;
        req_if.key     <= KEY_ZERO;
        cfg_if.valid   <= 1'b0;
        cfg_if.data    <= cdq_pkg::CAPACITY_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_after_reset();
        test_extreme_keys();
        test_zero_capacity();
        test_wraparound();
        test_random_phases();

        wait_idle();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/cdq_pkg.sv
rtl/core/cdq_if.sv
rtl/core/cdq_ctrl.sv
rtl/core/cdq_datapath.sv
rtl/core/circular_deque.sv
tb/circular_deque_tb.sv
